>>> rtl/rmrpy_pkg.sv
// Shared types, constants and helper functions for the rotation matrix to
// roll/pitch/yaw block. No dependencies.
package rmrpy_pkg;

  localparam int NUM_LANES  = 4;
  localparam int LANE_PITCH = 0;
  localparam int LANE_YAW   = 1;
  localparam int LANE_ROLL  = 2;  // atan2(r21, r22)
  localparam int LANE_SROLL = 3;  // atan2(r01, r11), used near +-90 deg

  localparam int SQRT_STEPS = 32;
  localparam int VW         = 36;  // CORDIC x/y width

  localparam logic [1:0]  SC_REGULAR = 2'd0;
  localparam logic [1:0]  SC_PLUS90  = 2'd1;
  localparam logic [1:0]  SC_MINUS90 = 2'd2;
  localparam logic [15:0] QUARTER    = 16'd16384;
  localparam logic [13:0] THR_RESET  = 14'd182;
  localparam logic [1:0]  ADDR_THR   = 2'd0;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r01;
    logic signed [15:0] r11;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } rot_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
    logic                 zero;
  } vec_t;

  typedef vec_t [NUM_LANES-1:0] lanes_t;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;  5'd31: v = 32'h00000000;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // Q2.14 entry scaled by 2^16
  function automatic logic signed [VW-1:0] ext_q(input logic signed [15:0] r);
    return {{(VW-32){r[15]}}, r, 16'h0000};
  endfunction

  // Fold the vector into the right half plane before the first rotation
  function automatic vec_t prep_lane(input logic signed [VW-1:0] y,
                                     input logic signed [VW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[VW-1]) begin
      v.x = -x;
      v.y = -y;
      v.z = 32'h8000_0000;
    end else begin
      v.x = x;
      v.y = y;
      v.z = 32'h0000_0000;
    end
    return v;
  endfunction

  function automatic logic [15:0] to_angle(input vec_t v);
    logic [31:0] s;
    s = v.z + 32'h0000_8000;
    return v.zero ? 16'h0000 : s[31:16];
  endfunction

endpackage

>>> rtl/rmrpy_sqrt_cell.sv
// One digit cell of the pipelined integer square root (two radicand bits a cell).
// Depends on rmrpy_pkg.
module rmrpy_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  logic [31:0]         sum_i,
  input  logic [35:0]         rem_i,
  input  logic [31:0]         root_i,
  input  rmrpy_pkg::rot_t     rot_i,
  output logic                valid_o,
  output logic [31:0]         sum_o,
  output logic [35:0]         rem_o,
  output logic [31:0]         root_o,
  output rmrpy_pkg::rot_t     rot_o
);

  localparam int PAIR = rmrpy_pkg::SQRT_STEPS - 1 - STEP;

  logic            valid_r;
  logic [31:0]     sum_r;
  logic [35:0]     rem_r, rem_nxt, rem_sh, trial;
  logic [31:0]     root_r, root_nxt;
  rmrpy_pkg::rot_t rot_r;
  logic [1:0]      bits;

  // radicand is sum << 32: its lower half is all zeros
  generate
    if (PAIR >= 16) begin : g_hi
      assign bits = sum_i[2*PAIR-32 +: 2];
    end else begin : g_lo
      assign bits = 2'b00;
    end
  endgenerate

  always_comb begin
    rem_sh = {rem_i[33:0], bits};
    trial  = {2'b00, root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_i[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_i[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rot_r  <= rot_i;
    end
  end

  assign valid_o = valid_r;
  assign sum_o   = sum_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign rot_o   = rot_r;

endmodule

>>> rtl/rmrpy_cordic_cell.sv
// One CORDIC vectoring iteration applied to all four angle lanes.
// Depends on rmrpy_pkg.
module rmrpy_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_i,
  input  rmrpy_pkg::lanes_t lanes_i,
  output logic              valid_o,
  output rmrpy_pkg::lanes_t lanes_o
);

  localparam logic [31:0] ANG = rmrpy_pkg::atan_entry(STAGE[4:0]);

  logic              valid_r;
  rmrpy_pkg::lanes_t lanes_r, lanes_nxt;

  always_comb begin
    for (int l = 0; l < rmrpy_pkg::NUM_LANES; l++) begin
      lanes_nxt[l].zero = lanes_i[l].zero;
      // y of zero counts as positive
      if (!lanes_i[l].y[rmrpy_pkg::VW-1]) begin
        lanes_nxt[l].x = lanes_i[l].x + (lanes_i[l].y >>> STAGE);
        lanes_nxt[l].y = lanes_i[l].y - (lanes_i[l].x >>> STAGE);
        lanes_nxt[l].z = lanes_i[l].z + ANG;
      end else begin
        lanes_nxt[l].x = lanes_i[l].x - (lanes_i[l].y >>> STAGE);
        lanes_nxt[l].y = lanes_i[l].y + (lanes_i[l].x >>> STAGE);
        lanes_nxt[l].z = lanes_i[l].z - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lanes_o = lanes_r;

endmodule

>>> rtl/rotation_matrix_to_roll_pitch_yaw.sv
// Top level: rotation matrix to ZYX yaw/pitch/roll, streaming in and out.
// Depends on rmrpy_pkg, rmrpy_sqrt_cell, rmrpy_cordic_cell.
//
// Usage:
//   in_*  : one transfer carries seven Q2.14 matrix entries.
//   out_* : one transfer carries yaw, pitch, roll (binary angles, 32768 = pi)
//           and the singular case code.
//   cfg_* : APB-style port; gimbal_threshold at byte address 0.
// Throughput: one matrix per cycle unless the receiver stalls. The pipeline is
// a square unit, a row of 32 square-root digit cells, a prepare stage and
// CORDIC_STAGES cells, each rotating all four angles in parallel, then the
// output register.
// Reset clears all valid flags and loads the threshold with 182.
// When the receiver stalls, one result waits in the output register and the
// next lands in a skid register; only then does the pipeline freeze and
// in_tready drop. Nothing is lost while stalled.
module rotation_matrix_to_roll_pitch_yaw #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rot_00, rot_10, rot_20, rot_01, rot_11, rot_21, rot_22 (16 b each)
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32],
  // singular_case[49:48], zero pad [55:50]
  output logic [55:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int NS = rmrpy_pkg::SQRT_STEPS;

  logic [13:0] thr_r;
  logic        en;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {18'd0, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rmrpy_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == rmrpy_pkg::ADDR_THR) begin
      thr_r <= cfg_pwdata[13:0];
    end
  end

  // square stage
  rmrpy_pkg::rot_t in_rot;
  logic            sq_valid_r;
  logic [31:0]     sq_sum_r;
  rmrpy_pkg::rot_t sq_rot_r;
  logic [31:0]     p00, p10;

  // r00 is the first struct member (top bits) but sits in the low tdata bits
  assign in_rot    = rmrpy_pkg::rot_t'({in_tdata[15:0], in_tdata[31:16], in_tdata[47:32],
                                        in_tdata[63:48], in_tdata[79:64], in_tdata[95:80],
                                        in_tdata[111:96]});
  assign in_tready = en;
  assign p00 = 32'(in_rot.r00 * in_rot.r00);
  assign p10 = 32'(in_rot.r10 * in_rot.r10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
    end else if (en) begin
      sq_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_sum_r <= p00 + p10;
      sq_rot_r <= in_rot;
    end
  end

  // square root chain
  logic            s_valid [NS+1];
  logic [31:0]     s_sum   [NS+1];
  logic [35:0]     s_rem   [NS+1];
  logic [31:0]     s_root  [NS+1];
  rmrpy_pkg::rot_t s_rot   [NS+1];

  assign s_valid[0] = sq_valid_r;
  assign s_sum[0]   = sq_sum_r;
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;
  assign s_rot[0]   = sq_rot_r;

  generate
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
      rmrpy_sqrt_cell #(.STEP(k)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (s_valid[k]),
        .sum_i   (s_sum[k]),
        .rem_i   (s_rem[k]),
        .root_i  (s_root[k]),
        .rot_i   (s_rot[k]),
        .valid_o (s_valid[k+1]),
        .sum_o   (s_sum[k+1]),
        .rem_o   (s_rem[k+1]),
        .root_o  (s_root[k+1]),
        .rot_o   (s_rot[k+1])
      );
    end
  endgenerate

  // prepare stage: set up the four atan2 operand pairs
  rmrpy_pkg::rot_t   pr;
  rmrpy_pkg::lanes_t prep;

  assign pr = s_rot[NS];

  always_comb begin
    prep[rmrpy_pkg::LANE_PITCH] = rmrpy_pkg::prep_lane(-rmrpy_pkg::ext_q(pr.r20),
                                    {{(rmrpy_pkg::VW-32){1'b0}}, s_root[NS]});
    prep[rmrpy_pkg::LANE_YAW]   = rmrpy_pkg::prep_lane(rmrpy_pkg::ext_q(pr.r10),
                                                        rmrpy_pkg::ext_q(pr.r00));
    prep[rmrpy_pkg::LANE_ROLL]  = rmrpy_pkg::prep_lane(rmrpy_pkg::ext_q(pr.r21),
                                                        rmrpy_pkg::ext_q(pr.r22));
    prep[rmrpy_pkg::LANE_SROLL] = rmrpy_pkg::prep_lane(rmrpy_pkg::ext_q(pr.r01),
                                                        rmrpy_pkg::ext_q(pr.r11));
  end

  logic              c_valid [CORDIC_STAGES+1];
  rmrpy_pkg::lanes_t c_lanes [CORDIC_STAGES+1];
  logic              pp_valid_r;
  rmrpy_pkg::lanes_t pp_lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_valid_r <= 1'b0;
    end else if (en) begin
      pp_valid_r <= s_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lanes_r <= prep;
    end
  end

  assign c_valid[0] = pp_valid_r;
  assign c_lanes[0] = pp_lanes_r;

  generate
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rmrpy_cordic_cell #(.STAGE(i)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (c_valid[i]),
        .lanes_i (c_lanes[i]),
        .valid_o (c_valid[i+1]),
        .lanes_o (c_lanes[i+1])
      );
    end
  endgenerate

  // result selection
  rmrpy_pkg::lanes_t fl;
  logic [15:0]       pitch, yaw_a, roll_a, sroll_a;
  logic [16:0]       dp, dm;
  logic [49:0]       res;
  logic              pop;

  assign fl      = c_lanes[CORDIC_STAGES];
  assign pitch   = rmrpy_pkg::to_angle(fl[rmrpy_pkg::LANE_PITCH]);
  assign yaw_a   = rmrpy_pkg::to_angle(fl[rmrpy_pkg::LANE_YAW]);
  assign roll_a  = rmrpy_pkg::to_angle(fl[rmrpy_pkg::LANE_ROLL]);
  assign sroll_a = rmrpy_pkg::to_angle(fl[rmrpy_pkg::LANE_SROLL]);

  always_comb begin
    dp = {pitch[15], pitch} - {1'b0, rmrpy_pkg::QUARTER};
    dm = {pitch[15], pitch} + {1'b0, rmrpy_pkg::QUARTER};
    if (dp[16]) dp = -dp;
    if (dm[16]) dm = -dm;
    // near +90 takes precedence when both tests hit
    priority if (dp < {3'b000, thr_r}) begin
      res = {rmrpy_pkg::SC_PLUS90, sroll_a, pitch, 16'h0000};
    end else if (dm < {3'b000, thr_r}) begin
      res = {rmrpy_pkg::SC_MINUS90, 16'h0000 - sroll_a, pitch, 16'h0000};
    end else begin
      res = {rmrpy_pkg::SC_REGULAR, roll_a, pitch, yaw_a};
    end
  end

  // output register with skid
  logic        out_valid_r, skid_valid_r;
  logic [49:0] out_data_r, skid_data_r;

  assign en  = !skid_valid_r;
  assign pop = en && c_valid[CORDIC_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= pop;
      end
    end else if (pop) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (pop) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r};

endmodule
